@@ hw/rtl/rfr_pkg.sv @@
// Shared types and codes for the request frame receiver.
`default_nettype none

package rfr_pkg;

  typedef enum logic [1:0] {
    ACT_RECEIVE = 2'd0,
    ACT_CLEAR   = 2'd1,
    ACT_READ    = 2'd2,
    ACT_UNUSED  = 2'd3
  } action_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] byte_value;
    logic [7:0] read_index;
  } req_t;

  typedef struct packed {
    logic        request_ready;
    logic        overflow_error;
    logic [2:0]  phase;
    logic [7:0]  command_byte;
    logic [7:0]  subfunction_byte;
    logic [15:0] payload_length;
    logic [31:0] frame_crc;
    logic [7:0]  read_data;
  } resp_t;

  // Number of buffer positions that an 8-bit read index can reach.
  localparam int unsigned READ_SPAN = 256;

endpackage

`default_nettype wire

@@ hw/rtl/rfr_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module rfr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                                       clk,
  input  wire logic                                       wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                           wr_data,
  input  wire logic                                       rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/request_frame_receiver.sv @@
// Request frame receiver: byte parser, payload buffer and result stage.
`default_nettype none

// Takes one request per clock unless stalled: a received byte, a clear, or a
// buffer read. Bytes build a frame of command, subfunction, 16-bit big-endian
// length, payload and 32-bit big-endian CRC (stored, never checked). The
// payload sits in a RAM with registered read, and every request leaves as
// one result carrying the parser state after that request; a new request may
// enter every cycle while unstalled. A result register and a one-deep stage
// behind the RAM read let one more request in while a result waits.
// Only the first 256 buffer positions can be read, so the RAM holds at most
// 256 bytes. Bytes fill the buffer in order from position zero, so the
// payload byte count doubles as a fill mark: a position at or past it reads
// as zero. A clear thus empties the buffer at once, with no clearing pass.
// A length above RX_BUFFER_BYTES raises a sticky overflow on the first
// payload byte; after a full frame or an error, bytes are dropped until a
// clear.

module request_frame_receiver #(
  parameter int unsigned RX_BUFFER_BYTES = 256
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          request_valid,
  output logic               request_stall,
  input  wire rfr_pkg::req_t request,
  output logic               result_valid,
  input  wire logic          result_stall,
  output rfr_pkg::resp_t     result
);

  // RAM only needs the positions that a read can reach.
  localparam int unsigned MEM_DEPTH =
    (RX_BUFFER_BYTES < rfr_pkg::READ_SPAN) ? RX_BUFFER_BYTES : rfr_pkg::READ_SPAN;
  localparam int unsigned ADDR_W = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam logic [16:0] LEN_LIMIT = 17'(RX_BUFFER_BYTES);
  localparam logic [16:0] MEM_LIMIT = 17'(MEM_DEPTH);

  typedef enum logic [2:0] {
    PH_COMMAND     = 3'd0,
    PH_SUBFUNCTION = 3'd1,
    PH_LENGTH      = 3'd2,
    PH_PAYLOAD     = 3'd3,
    PH_CRC         = 3'd4,
    PH_READY       = 3'd5,
    PH_ERROR       = 3'd6
  } phase_state_t;

  phase_state_t phase_reg, phase_reg_next;
  logic         length_bytes_seen, length_bytes_seen_next;
  logic [15:0]  payload_bytes_seen, payload_bytes_seen_next;
  logic [1:0]   crc_bytes_seen, crc_bytes_seen_next;
  logic [7:0]   command_reg, command_reg_next;
  logic [7:0]   subfunction_reg, subfunction_reg_next;
  logic [15:0]  length_reg, length_reg_next;
  logic [31:0]  crc_reg, crc_reg_next;
  logic         ready_flag, ready_flag_next;
  logic         error_flag, error_flag_next;

  logic         accept;
  logic         stage_valid;
  logic         stage_hit;
  logic         stage_adv;
  logic         read_hit;
  logic         buf_wr;
  logic [7:0]   ram_q;
  logic [15:0]  seen_inc;
  logic [31:0]  crc_base;
  logic [31:0]  crc_byte;

  // Hold the request while the stage behind the RAM cannot move on.
  assign stage_adv     = !result_valid || !result_stall;
  assign request_stall = stage_valid && !stage_adv;
  assign accept        = request_valid && !request_stall;

  assign seen_inc = payload_bytes_seen + 16'd1;
  assign crc_base = (crc_bytes_seen == 2'd0) ? 32'd0 : crc_reg;

  // Place the CRC byte, most significant first.
  always_comb begin
    case (crc_bytes_seen)
      2'd0:    crc_byte = {request.byte_value, 24'd0};
      2'd1:    crc_byte = {8'd0, request.byte_value, 16'd0};
      2'd2:    crc_byte = {16'd0, request.byte_value, 8'd0};
      default: crc_byte = {24'd0, request.byte_value};
    endcase
  end

  // A position is live only if it lies below the fill mark.
  assign read_hit = (rfr_pkg::action_t'(request.action) == rfr_pkg::ACT_READ)
                  && (17'(request.read_index) < MEM_LIMIT)
                  && (16'(request.read_index) < payload_bytes_seen);

  always_comb begin
    phase_reg_next          = phase_reg;
    length_bytes_seen_next  = length_bytes_seen;
    payload_bytes_seen_next = payload_bytes_seen;
    crc_bytes_seen_next     = crc_bytes_seen;
    command_reg_next        = command_reg;
    subfunction_reg_next    = subfunction_reg;
    length_reg_next         = length_reg;
    crc_reg_next            = crc_reg;
    ready_flag_next         = ready_flag;
    error_flag_next         = error_flag;
    buf_wr                  = 1'b0;

    if (accept) begin
      unique case (rfr_pkg::action_t'(request.action))
        rfr_pkg::ACT_RECEIVE: begin
          unique case (phase_reg)
            PH_COMMAND: begin
              command_reg_next = request.byte_value;
              phase_reg_next   = PH_SUBFUNCTION;
            end
            PH_SUBFUNCTION: begin
              subfunction_reg_next = request.byte_value;
              phase_reg_next       = PH_LENGTH;
            end
            PH_LENGTH: begin
              if (!length_bytes_seen) begin
                length_reg_next        = {request.byte_value, 8'd0};
                length_bytes_seen_next = 1'b1;
              end else begin
                length_reg_next        = {length_reg[15:8], request.byte_value};
                length_bytes_seen_next = 1'b0;
                phase_reg_next = ({length_reg[15:8], request.byte_value} == 16'd0)
                               ? PH_CRC : PH_PAYLOAD;
              end
            end
            PH_PAYLOAD: begin
              if (17'(length_reg) > LEN_LIMIT) begin
                // Drop the byte and latch the overflow.
                error_flag_next = 1'b1;
                phase_reg_next  = PH_ERROR;
              end else begin
                buf_wr                  = 17'(payload_bytes_seen) < MEM_LIMIT;
                payload_bytes_seen_next = seen_inc;
                if (seen_inc >= length_reg) begin
                  phase_reg_next = PH_CRC;
                end
              end
            end
            PH_CRC: begin
              crc_reg_next = crc_base | crc_byte;
              if (crc_bytes_seen == 2'd3) begin
                crc_bytes_seen_next = 2'd0;
                ready_flag_next     = 1'b1;
                phase_reg_next      = PH_READY;
              end else begin
                crc_bytes_seen_next = crc_bytes_seen + 2'd1;
              end
            end
            default: begin
            end
          endcase
        end
        rfr_pkg::ACT_CLEAR: begin
          // Dropping the fill mark empties the buffer.
          phase_reg_next          = PH_COMMAND;
          length_bytes_seen_next  = 1'b0;
          payload_bytes_seen_next = 16'd0;
          crc_bytes_seen_next     = 2'd0;
          command_reg_next        = 8'd0;
          subfunction_reg_next    = 8'd0;
          length_reg_next         = 16'd0;
          crc_reg_next            = 32'd0;
          ready_flag_next         = 1'b0;
          error_flag_next         = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  rfr_ram #(
    .WIDTH (8),
    .DEPTH (MEM_DEPTH)
  ) u_buffer (
    .clk     (clk),
    .wr_en   (buf_wr),
    .wr_addr (payload_bytes_seen[ADDR_W-1:0]),
    .wr_data (request.byte_value),
    .rd_en   (accept),
    .rd_addr (request.read_index[ADDR_W-1:0]),
    .rd_data (ram_q)
  );

  // Parser state, the stage behind the RAM read and the result register.
  // The parser state always reflects the last accepted request, so the
  // result takes it as the stage moves out.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg          <= PH_COMMAND;
      length_bytes_seen  <= 1'b0;
      payload_bytes_seen <= 16'd0;
      crc_bytes_seen     <= 2'd0;
      command_reg        <= 8'd0;
      subfunction_reg    <= 8'd0;
      length_reg         <= 16'd0;
      crc_reg            <= 32'd0;
      ready_flag         <= 1'b0;
      error_flag         <= 1'b0;
      stage_valid        <= 1'b0;
      result_valid       <= 1'b0;
    end else begin
      phase_reg          <= phase_reg_next;
      length_bytes_seen  <= length_bytes_seen_next;
      payload_bytes_seen <= payload_bytes_seen_next;
      crc_bytes_seen     <= crc_bytes_seen_next;
      command_reg        <= command_reg_next;
      subfunction_reg    <= subfunction_reg_next;
      length_reg         <= length_reg_next;
      crc_reg            <= crc_reg_next;
      ready_flag         <= ready_flag_next;
      error_flag         <= error_flag_next;
      if (accept) begin
        stage_valid <= 1'b1;
      end else if (stage_adv) begin
        stage_valid <= 1'b0;
      end
      if (stage_adv) begin
        result_valid <= stage_valid;
      end
    end
    if (accept) begin
      stage_hit <= read_hit;
    end
    if (stage_valid && stage_adv) begin
      result.request_ready    <= ready_flag;
      result.overflow_error   <= error_flag;
      result.phase            <= phase_reg;
      result.command_byte     <= command_reg;
      result.subfunction_byte <= subfunction_reg;
      result.payload_length   <= length_reg;
      result.frame_crc        <= crc_reg;
      result.read_data        <= stage_hit ? ram_q : 8'd0;
    end
  end

endmodule

`default_nettype wire
